@@ hdl/efa_pkg.sv @@
// Shared constants and interface types for the EVM frame averager.
package efa_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAG_W       = SAMPLE_BITS + 1;
  localparam int PROD_W      = 2 * MAG_W;
  localparam int ACC_W       = 48;
  localparam int WIN_W       = 5;
  localparam int MINREF_W    = 32;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int SUM_W       = 29;
  localparam int PCT_W       = 19;
  localparam int EVM_W       = 25;
  localparam int RATIO_W     = ACC_W + 1;
  localparam int FRAC_BITS   = 40;
  localparam int CAP_SHIFT   = ACC_W - FRAC_BITS;
  localparam int SUB_W       = ACC_W + CAP_SHIFT;
  localparam int PCT_FRAC    = 12;
  localparam int SCALED_W    = SUM_W + 7 - PCT_FRAC;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_FRAMES  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_REF_ENERGY = 1'd1;

  localparam logic [WIN_W-1:0]    WINDOW_RESET = 5'd10;
  localparam logic [MINREF_W-1:0] MINREF_RESET = 32'd1074;
  localparam logic [EVM_W-1:0]    EVM_FLOOR    = 25'd10;

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] err_e;
    logic [ACC_W-1:0] ref_e;
  } efa_req_t;

  typedef struct packed {
    logic             valid;
    logic [PCT_W-1:0] pct;
    logic             done;
  } efa_res_t;

  typedef struct packed {
    logic [WIN_W-1:0]    window_frames;
    logic [MINREF_W-1:0] min_ref_energy;
  } efa_cfg_t;

endpackage

@@ hdl/efa_core.sv @@
// Frame-end sequencer: ratio divide, square root, running average and percent divide.
module efa_core (
  input  logic              clk,
  input  logic              rst,
  input  efa_pkg::efa_req_t req,
  input  efa_pkg::efa_cfg_t cfg,
  input  logic              take,
  output efa_pkg::efa_res_t res
);
  import efa_pkg::*;

  localparam int CNT_W = $clog2(ACC_W + 1);

  typedef enum logic [3:0] {
    C_IDLE, C_CHK_REF, C_CHK_CAP, C_DIV, C_ROOT_SET, C_SQRT,
    C_SUM, C_SCALE, C_PCT, C_WIN, C_OUT
  } state_t;

  state_t               state;
  logic [ACC_W-1:0]     err_e;
  logic [ACC_W-1:0]     ref_e;
  logic [RATIO_W-1:0]   x;
  logic [RATIO_W-1:0]   y;
  logic [RATIO_W-1:0]   z;
  logic [CNT_W-1:0]     cnt;
  logic [EVM_W-1:0]     evm;
  logic [SUM_W-1:0]     sum;
  logic [WIN_W-1:0]     fc;
  logic [PCT_W-1:0]     pct;
  logic                 done;

  logic [SUB_W-1:0]     a_op;
  logic [SUB_W-1:0]     b_op;
  logic [SUB_W:0]       diff;
  logic                 ge;
  logic [RATIO_W-1:0]   root_next;
  logic [SUM_W:0]       sum_add;
  logic [SUM_W-1:0]     sum_sat;
  logic [SUM_W+6:0]     sum_x100;
  logic [WIN_W-1:0]     fc_inc;
  logic [WIN_W-1:0]     limit;

  // shared subtractor, operands picked by the sequencer
  always_comb begin
    a_op = '0;
    b_op = '0;
    unique case (state)
      C_CHK_REF: begin
        a_op = SUB_W'(cfg.min_ref_energy);
        b_op = SUB_W'(ref_e);
      end
      C_CHK_CAP: begin
        a_op = SUB_W'(err_e);
        b_op = {ref_e, {CAP_SHIFT{1'b0}}};
      end
      C_DIV: begin
        a_op = SUB_W'({x[ACC_W-1:0], y[ACC_W-1]});
        b_op = SUB_W'(ref_e);
      end
      C_SQRT: begin
        a_op = SUB_W'(x);
        b_op = SUB_W'(y | z);
      end
      C_PCT: begin
        a_op = SUB_W'({x[WIN_W-1:0], y[SCALED_W-1]});
        b_op = SUB_W'(fc);
      end
      default: ;
    endcase
    diff = {1'b0, a_op} - {1'b0, b_op};
    ge   = ~diff[SUB_W];
  end

  always_comb begin
    root_next = ge ? ((y >> 1) | z) : (y >> 1);
    sum_add   = {1'b0, sum} + (SUM_W + 1)'(evm);
    sum_sat   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    sum_x100  = ((SUM_W + 7)'(sum) << 6) + ((SUM_W + 7)'(sum) << 5)
              + ((SUM_W + 7)'(sum) << 2);
    fc_inc    = (fc == '1) ? WIN_W'(1) : fc + WIN_W'(1);
    limit     = (cfg.window_frames == '0) ? WIN_W'(1) : cfg.window_frames;
  end

  always_comb begin
    res.valid = (state == C_OUT);
    res.pct   = pct;
    res.done  = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      sum   <= '0;
      fc    <= '0;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (req.start) begin
            err_e <= req.err_e;
            ref_e <= req.ref_e;
            state <= C_CHK_REF;
          end
        end
        C_CHK_REF: begin
          if (ge) begin
            evm   <= EVM_FLOOR;
            state <= C_SUM;
          end else begin
            state <= C_CHK_CAP;
          end
        end
        C_CHK_CAP: begin
          if (ge) begin
            // ratio clamps at 256
            x     <= {1'b1, {ACC_W{1'b0}}};
            y     <= '0;
            z     <= {1'b1, {ACC_W{1'b0}}};
            cnt   <= CNT_W'(EVM_W - 1);
            state <= C_SQRT;
          end else begin
            x     <= RATIO_W'(err_e >> CAP_SHIFT);
            y     <= RATIO_W'({err_e[CAP_SHIFT-1:0], {FRAC_BITS{1'b0}}});
            cnt   <= CNT_W'(ACC_W - 1);
            state <= C_DIV;
          end
        end
        C_DIV: begin
          x <= ge ? diff[RATIO_W-1:0] : a_op[RATIO_W-1:0];
          y <= {y[RATIO_W-2:0], ge};
          if (cnt == '0) begin
            state <= C_ROOT_SET;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        C_ROOT_SET: begin
          x     <= {1'b0, y[ACC_W-1:0]};
          y     <= '0;
          z     <= {1'b1, {ACC_W{1'b0}}};
          cnt   <= CNT_W'(EVM_W - 1);
          state <= C_SQRT;
        end
        C_SQRT: begin
          if (ge) begin
            x <= diff[RATIO_W-1:0];
          end
          y <= root_next;
          z <= z >> 2;
          if (cnt == '0) begin
            evm   <= root_next[EVM_W-1:0];
            state <= C_SUM;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        C_SUM: begin
          sum   <= sum_sat;
          fc    <= fc_inc;
          state <= C_SCALE;
        end
        C_SCALE: begin
          x     <= '0;
          y     <= RATIO_W'(sum_x100[SUM_W+6:PCT_FRAC]);
          cnt   <= CNT_W'(SCALED_W - 1);
          state <= C_PCT;
        end
        C_PCT: begin
          x <= ge ? diff[RATIO_W-1:0] : a_op[RATIO_W-1:0];
          y <= {y[RATIO_W-2:0], ge};
          if (cnt == '0) begin
            state <= C_WIN;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        C_WIN: begin
          pct  <= (y[SCALED_W-1:PCT_W] != '0) ? '1 : y[PCT_W-1:0];
          done <= (fc >= limit);
          if (fc >= limit) begin
            sum <= '0;
            fc  <= '0;
          end
          state <= C_OUT;
        end
        C_OUT: begin
          if (take) begin
            state <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/evm_frame_averager.sv @@
// Top level of the running-average EVM block: sample accumulation, config and output.
//
// Input channel (in_valid / in_stall): one request carries a measured and a reference
// complex sample plus last_sample. in_stall is high while a request is being worked on.
// Each sample is accepted, then squared in four steps through one 17x17 multiplier
// with a product register, accumulated into saturating 48-bit energy registers.
// On a request with last_sample set the frame-end sequence follows:
// a 48-step ratio divide, a 25-step square root and a 24-step percent divide, all
// through one shared 57-bit subtractor. One result then loads the output register.
// Output channel (out_valid / out_stall): a result waits in the output register while
// the next frame is accumulated; only a second frame end waits for it to be taken.
// Configuration: cfg_we writes window_frames (index 0) or min_ref_energy (index 1).
// Reset clears energies, running sum, frame count and output valid, and loads the
// register defaults (window 10, threshold 1074).
module evm_frame_averager (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [efa_pkg::SAMPLE_BITS-1:0] meas_i,
  input  logic signed [efa_pkg::SAMPLE_BITS-1:0] meas_q,
  input  logic signed [efa_pkg::SAMPLE_BITS-1:0] ref_i,
  input  logic signed [efa_pkg::SAMPLE_BITS-1:0] ref_q,
  input  logic                                last_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [efa_pkg::PCT_W-1:0]           evm_percent,
  output logic                                window_done,
  input  logic                                cfg_we,
  input  logic [efa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [efa_pkg::CFG_W-1:0]           cfg_data
);
  import efa_pkg::*;

  localparam int NUM_OPS  = 4;
  localparam int SQ_CNT_W = $clog2(NUM_OPS + 1);
  localparam int OP_IDX_W = $clog2(NUM_OPS);

  typedef enum logic [1:0] {T_IDLE, T_SQ, T_FRAME} state_t;

  function automatic logic [MAG_W-1:0] mag(input logic signed [MAG_W-1:0] v);
    mag = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  state_t                 state;
  logic [MAG_W-1:0]       op [NUM_OPS];
  logic                   last;
  logic [SQ_CNT_W-1:0]    sq_cnt;
  logic [PROD_W-1:0]      prod;
  logic [PROD_W-1:0]      sq_val;
  logic [ACC_W-1:0]       ref_acc;
  logic [ACC_W-1:0]       err_acc;
  logic [ACC_W-1:0]       acc_sel;
  logic [ACC_W:0]         acc_sum;
  logic [ACC_W-1:0]       acc_sat;
  logic                   req_start;
  logic [WIN_W-1:0]       window_frames;
  logic [MINREF_W-1:0]    min_ref_energy;
  logic signed [MAG_W-1:0] mi_x, mq_x, ri_x, rq_x;
  logic                   accept;
  logic                   take;
  efa_req_t               req;
  efa_res_t               res;
  efa_cfg_t               cfg;

  assign in_stall = (state != T_IDLE);
  assign accept   = in_valid && !in_stall;
  assign take     = res.valid && (!out_valid || !out_stall);

  always_comb begin
    mi_x    = MAG_W'(meas_i);
    mq_x    = MAG_W'(meas_q);
    ri_x    = MAG_W'(ref_i);
    rq_x    = MAG_W'(ref_q);
    sq_val  = PROD_W'(op[sq_cnt[OP_IDX_W-1:0]]) * PROD_W'(op[sq_cnt[OP_IDX_W-1:0]]);
    acc_sel = (sq_cnt <= SQ_CNT_W'(2)) ? ref_acc : err_acc;
    acc_sum = {1'b0, acc_sel} + (ACC_W + 1)'(prod);
    acc_sat = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
    req     = '{start: req_start, err_e: err_acc, ref_e: ref_acc};
    cfg     = '{window_frames: window_frames, min_ref_energy: min_ref_energy};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_frames  <= WINDOW_RESET;
      min_ref_energy <= MINREF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_FRAMES:  window_frames  <= cfg_data[WIN_W-1:0];
        REG_MIN_REF_ENERGY: min_ref_energy <= cfg_data[MINREF_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      req_start <= 1'b0;
      ref_acc   <= '0;
      err_acc   <= '0;
    end else begin
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            op[0]  <= mag(ri_x);
            op[1]  <= mag(rq_x);
            op[2]  <= mag(mi_x - ri_x);
            op[3]  <= mag(mq_x - rq_x);
            last   <= last_sample;
            sq_cnt <= '0;
            state  <= T_SQ;
          end
        end
        T_SQ: begin
          // product of step n is accumulated at step n+1
          if (sq_cnt != SQ_CNT_W'(NUM_OPS)) begin
            prod <= sq_val;
          end
          if (sq_cnt != '0) begin
            if (sq_cnt <= SQ_CNT_W'(2)) begin
              ref_acc <= acc_sat;
            end else begin
              err_acc <= acc_sat;
            end
          end
          if (sq_cnt == SQ_CNT_W'(NUM_OPS)) begin
            req_start <= last;
            state     <= last ? T_FRAME : T_IDLE;
          end
          sq_cnt <= sq_cnt + SQ_CNT_W'(1);
        end
        T_FRAME: begin
          req_start <= 1'b0;
          if (take) begin
            ref_acc <= '0;
            err_acc <= '0;
            state   <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid   <= 1'b1;
      evm_percent <= res.pct;
      window_done <= res.done;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  efa_core u_core (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cfg  (cfg),
    .take (take),
    .res  (res)
  );

  a_res_in_frame: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> state == T_FRAME)
    else $error("frame result outside frame-end wait");

  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    take |=> (ref_acc == '0 && err_acc == '0))
    else $error("energy accumulators not cleared after frame end");

  a_start_pulse: assert property (@(posedge clk) disable iff (rst)
    req.start |=> !req.start)
    else $error("frame start held longer than one cycle");

endmodule
